// File: src/cmfts_pkg.sv
package cmfts_pkg;

  // Field widths
  localparam int COORD_W       = 16;
  localparam int SIZE_W        = 16;
  localparam int TEXEL_W       = 15;
  localparam int INDEX_W       = 30;
  localparam int FACE_W        = 3;
  localparam int MAX_FACE_SIZE = 32768;
  localparam int SIZE_RESET    = 256;

  // Datapath widths: major magnitude, offsets and the divider
  localparam int MAG_W      = COORD_W + 1;
  localparam int DEN_W      = MAG_W + 1;
  localparam int NUM_W      = MAG_W + SIZE_W;
  localparam int QUO_W      = SIZE_W;
  localparam int REM_W      = DEN_W;
  localparam int DIV_STEP   = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEP;

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  typedef enum logic [FACE_W-1:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  // Classified request as it travels through the queue
  typedef struct packed {
    logic               nonzero;
    face_t              face;
    logic [MAG_W-1:0]   major;
    logic [MAG_W-1:0]   u_off;
    logic [MAG_W-1:0]   v_off;
    logic [SIZE_W-1:0]  size;
  } item_t;

endpackage

// File: src/cmfts_if.sv
interface cmfts_in_if import cmfts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] dir_x;
  logic signed [COORD_W-1:0] dir_y;
  logic signed [COORD_W-1:0] dir_z;

  modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

interface cmfts_out_if import cmfts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [FACE_W-1:0]  face;
  logic [TEXEL_W-1:0] texel_x;
  logic [TEXEL_W-1:0] texel_y;
  logic [INDEX_W-1:0] texel_index;

  modport source (output valid, output valid_res, output face, output texel_x,
                  output texel_y, output texel_index, input ready);
  modport sink   (input valid, input valid_res, input face, input texel_x,
                  input texel_y, input texel_index, output ready);
endinterface

interface cmfts_cfg_if import cmfts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] edge_len;

  modport source (output valid, output edge_len, input ready);
  modport sink   (input valid, input edge_len, output ready);
endinterface

// File: src/cube_map_face_texel_select.sv
// Cube map face and texel select.
// in_if carries one direction request (dir_x, dir_y, dir_z) per valid/ready
// handshake; out_if returns one result per request, in order: valid_res,
// face (0 +X .. 5 -Z), texel_x, texel_y and texel_index = row * size + col.
// A zero direction returns valid_res 0 with every other field 0.
// cfg_if writes edge_len; it is always ready and should only be written
// while no request is in flight. Size 0 is used as 1, sizes above 32768 as
// 32768. Reset sets edge_len to 256 and empties the block.
// Throughput: one request per cycle while out_if.ready holds. Between acceptance
// and out_if.valid lie the queue, one multiply stage, the divider of eight
// stages of two quotient bits each, one clamp stage and the index and output
// register.
// A four-entry queue sits between classification and the arithmetic
// pipeline. When out_if.ready is low the pipeline stages fill up, then the
// queue, and only then does in_if.ready drop.
module cube_map_face_texel_select import cmfts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cmfts_in_if.sink    in_if,
  cmfts_out_if.source out_if,
  cmfts_cfg_if.sink   cfg_if
);

  logic [SIZE_W-1:0] edge_len_r, edge_len_nxt;
  logic              q_push;
  logic              q_full;
  logic              q_pop;
  logic              head_valid;
  item_t             q_item;
  item_t             head;

  // Face size register
  assign cfg_if.ready = 1'b1;
  assign edge_len_nxt = cfg_if.valid ? cfg_if.edge_len : edge_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_len_r <= SIZE_W'(SIZE_RESET);
    end else begin
      edge_len_r <= edge_len_nxt;
    end
  end

  cmfts_front u_front (
    .in_if    (in_if),
    .edge_len (edge_len_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  cmfts_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop)
  );

  cmfts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .out_if     (out_if)
  );

endmodule

// File: src/cmfts_front.sv
module cmfts_front import cmfts_pkg::*; (
  cmfts_in_if.sink          in_if,
  input  logic [SIZE_W-1:0] edge_len,
  input  logic              q_full,
  output logic              q_push,
  output item_t             q_item
);

  logic signed [DEN_W-1:0] sx, sy, sz;
  logic signed [DEN_W-1:0] ax_s, ay_s, az_s;
  logic [MAG_W-1:0]        ax, ay, az;
  logic signed [DEN_W-1:0] maj_s, u_s, v_s, u_sum, v_sum;
  face_t                   face;
  logic [SIZE_W-1:0]       size_eff;

  // Take a request whenever the queue has room
  assign in_if.ready = !q_full;
  assign q_push      = in_if.valid && !q_full;

  // Sign-extend and take magnitudes
  assign sx = {{(DEN_W-COORD_W){in_if.dir_x[COORD_W-1]}}, in_if.dir_x};
  assign sy = {{(DEN_W-COORD_W){in_if.dir_y[COORD_W-1]}}, in_if.dir_y};
  assign sz = {{(DEN_W-COORD_W){in_if.dir_z[COORD_W-1]}}, in_if.dir_z};

  assign ax_s = sx[DEN_W-1] ? -sx : sx;
  assign ay_s = sy[DEN_W-1] ? -sy : sy;
  assign az_s = sz[DEN_W-1] ? -sz : sz;
  assign ax   = ax_s[MAG_W-1:0];
  assign ay   = ay_s[MAG_W-1:0];
  assign az   = az_s[MAG_W-1:0];

  // Pick the major axis, X before Y before Z on ties, and the face's u and v
  always_comb begin
    if (ax >= ay && ax >= az) begin
      maj_s = ax_s;
      v_s   = -sy;
      if (!sx[DEN_W-1] && sx != '0) begin
        face = FACE_POS_X;
        u_s  = -sz;
      end else begin
        face = FACE_NEG_X;
        u_s  = sz;
      end
    end else if (ay >= az) begin
      maj_s = ay_s;
      u_s   = sx;
      if (!sy[DEN_W-1]) begin
        face = FACE_POS_Y;
        v_s  = sz;
      end else begin
        face = FACE_NEG_Y;
        v_s  = -sz;
      end
    end else begin
      maj_s = az_s;
      v_s   = -sy;
      if (!sz[DEN_W-1]) begin
        face = FACE_POS_Z;
        u_s  = sx;
      end else begin
        face = FACE_NEG_Z;
        u_s  = -sx;
      end
    end
  end

  // Shift minors onto 0..2*major
  assign u_sum = maj_s + u_s;
  assign v_sum = maj_s + v_s;

  // Clamp the face size into 1..MAX_FACE_SIZE
  always_comb begin
    if (edge_len == '0) begin
      size_eff = SIZE_W'(1);
    end else if (edge_len > SIZE_W'(MAX_FACE_SIZE)) begin
      size_eff = SIZE_W'(MAX_FACE_SIZE);
    end else begin
      size_eff = edge_len;
    end
  end

  assign q_item.nonzero = (in_if.dir_x != '0) || (in_if.dir_y != '0) || (in_if.dir_z != '0);
  assign q_item.face    = face;
  assign q_item.major   = maj_s[MAG_W-1:0];
  assign q_item.u_off   = u_sum[MAG_W-1:0];
  assign q_item.v_off   = v_sum[MAG_W-1:0];
  assign q_item.size    = size_eff;

endmodule

// File: src/cmfts_queue.sv
module cmfts_queue import cmfts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  head_valid,
  output item_t head,
  input  logic  pop
);

  item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= QCNT_W'(QDEPTH))
    else $error("queue occupancy above depth");

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> count_r != '0)
    else $error("queue popped while empty");

  assert property (@(posedge clk) disable iff (!rst_n) push |-> !full || pop)
    else $error("queue pushed while full");

endmodule

// File: src/cmfts_back.sv
module cmfts_back import cmfts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  item_t       head,
  output logic        pop,
  cmfts_out_if.source out_if
);

  typedef struct packed {
    logic              nonzero;
    face_t             face;
    logic [DEN_W-1:0]  den;
    logic [SIZE_W-1:0] size;
    logic [REM_W-1:0]  rem_u;
    logic [REM_W-1:0]  rem_v;
    logic [QUO_W-1:0]  low_u;
    logic [QUO_W-1:0]  low_v;
    logic [QUO_W-1:0]  quo_u;
    logic [QUO_W-1:0]  quo_v;
  } div_slot_t;

  typedef struct packed {
    logic               nonzero;
    face_t              face;
    logic [SIZE_W-1:0]  size;
    logic [TEXEL_W-1:0] tx;
    logic [TEXEL_W-1:0] ty;
  } clamp_t;

  // Several restoring divide steps on both coordinates
  function automatic div_slot_t div_step(input div_slot_t s);
    div_slot_t      t;
    logic [REM_W:0] tu;
    logic [REM_W:0] tv;
    logic           qu;
    logic           qv;
    t = s;
    for (int k = 0; k < DIV_STEP; k++) begin
      tu = {t.rem_u, t.low_u[QUO_W-1]};
      tv = {t.rem_v, t.low_v[QUO_W-1]};
      qu = (tu >= {1'b0, t.den});
      qv = (tv >= {1'b0, t.den});
      if (qu) begin
        tu = tu - {1'b0, t.den};
      end
      if (qv) begin
        tv = tv - {1'b0, t.den};
      end
      t.rem_u = tu[REM_W-1:0];
      t.rem_v = tv[REM_W-1:0];
      t.low_u = {t.low_u[QUO_W-2:0], 1'b0};
      t.low_v = {t.low_v[QUO_W-2:0], 1'b0};
      t.quo_u = {t.quo_u[QUO_W-2:0], qu};
      t.quo_v = {t.quo_v[QUO_W-2:0], qv};
    end
    return t;
  endfunction

  logic                   mul_v_r, mul_v_nxt;
  div_slot_t              mul_r, mul_nxt;
  logic [NUM_W-1:0]       num_u, num_v;
  logic [DIV_STAGES-1:0]  dv_r, dv_nxt;
  div_slot_t              dslot_r   [DIV_STAGES];
  div_slot_t              dslot_nxt [DIV_STAGES];
  logic [DIV_STAGES-1:0]  en_div;
  logic                   clp_v_r, clp_v_nxt;
  clamp_t                 clp_r, clp_nxt;
  div_slot_t              dlast;
  logic                   out_v_r, out_v_nxt;
  logic                   out_valid_res_r, out_valid_res_nxt;
  face_t                  out_face_r, out_face_nxt;
  logic [TEXEL_W-1:0]     out_tx_r, out_tx_nxt;
  logic [TEXEL_W-1:0]     out_ty_r, out_ty_nxt;
  logic [INDEX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [TEXEL_W+SIZE_W-1:0] idx_sum;
  logic                   en_out, en_clp, en_mul;

  // Stage enables: a stage loads when empty or when the next one moves
  always_comb begin
    en_out = !out_v_r || out_if.ready;
    en_clp = !clp_v_r || en_out;
    en_div[DIV_STAGES-1] = !dv_r[DIV_STAGES-1] || en_clp;
    for (int i = DIV_STAGES - 2; i >= 0; i--) begin
      en_div[i] = !dv_r[i] || en_div[i+1];
    end
    en_mul = !mul_v_r || en_div[0];
  end

  assign pop = head_valid && en_mul;

  // Scale offsets by the face size and seed the divider
  assign num_u = NUM_W'(head.u_off) * NUM_W'(head.size);
  assign num_v = NUM_W'(head.v_off) * NUM_W'(head.size);

  always_comb begin
    mul_v_nxt = en_mul ? head_valid : mul_v_r;
    mul_nxt   = mul_r;
    if (en_mul) begin
      mul_nxt.nonzero = head.nonzero;
      mul_nxt.face    = head.face;
      mul_nxt.den     = {head.major, 1'b0};
      mul_nxt.size    = head.size;
      mul_nxt.rem_u   = REM_W'(num_u[NUM_W-1:QUO_W]);
      mul_nxt.rem_v   = REM_W'(num_v[NUM_W-1:QUO_W]);
      mul_nxt.low_u   = num_u[QUO_W-1:0];
      mul_nxt.low_v   = num_v[QUO_W-1:0];
      mul_nxt.quo_u   = '0;
      mul_nxt.quo_v   = '0;
    end
  end

  // Divider pipeline
  always_comb begin
    for (int i = 0; i < DIV_STAGES; i++) begin
      if (i == 0) begin
        dv_nxt[i]    = en_div[i] ? mul_v_r : dv_r[i];
        dslot_nxt[i] = en_div[i] ? div_step(mul_r) : dslot_r[i];
      end else begin
        dv_nxt[i]    = en_div[i] ? dv_r[i-1] : dv_r[i];
        dslot_nxt[i] = en_div[i] ? div_step(dslot_r[i-1]) : dslot_r[i];
      end
    end
  end

  // Clamp quotients to the last texel of the face
  assign dlast = dslot_r[DIV_STAGES-1];

  always_comb begin
    clp_v_nxt = en_clp ? dv_r[DIV_STAGES-1] : clp_v_r;
    clp_nxt   = clp_r;
    if (en_clp) begin
      clp_nxt.nonzero = dlast.nonzero;
      clp_nxt.face    = dlast.face;
      clp_nxt.size    = dlast.size;
      clp_nxt.tx = (dlast.quo_u >= dlast.size) ? TEXEL_W'(dlast.size - 1'b1)
                                               : TEXEL_W'(dlast.quo_u);
      clp_nxt.ty = (dlast.quo_v >= dlast.size) ? TEXEL_W'(dlast.size - 1'b1)
                                               : TEXEL_W'(dlast.quo_v);
    end
  end

  // Linear index and output register; zero direction drives all zeros
  assign idx_sum = (TEXEL_W+SIZE_W)'(clp_r.ty) * (TEXEL_W+SIZE_W)'(clp_r.size) +
                   (TEXEL_W+SIZE_W)'(clp_r.tx);

  always_comb begin
    out_v_nxt         = en_out ? clp_v_r : out_v_r;
    out_valid_res_nxt = out_valid_res_r;
    out_face_nxt      = out_face_r;
    out_tx_nxt        = out_tx_r;
    out_ty_nxt        = out_ty_r;
    out_idx_nxt       = out_idx_r;
    if (en_out) begin
      out_valid_res_nxt = clp_r.nonzero;
      if (clp_r.nonzero) begin
        out_face_nxt = clp_r.face;
        out_tx_nxt   = clp_r.tx;
        out_ty_nxt   = clp_r.ty;
        out_idx_nxt  = idx_sum[INDEX_W-1:0];
      end else begin
        out_face_nxt = FACE_POS_X;
        out_tx_nxt   = '0;
        out_ty_nxt   = '0;
        out_idx_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
      dv_r    <= '0;
      clp_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      mul_v_r <= mul_v_nxt;
      dv_r    <= dv_nxt;
      clp_v_r <= clp_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_r           <= mul_nxt;
    dslot_r         <= dslot_nxt;
    clp_r           <= clp_nxt;
    out_valid_res_r <= out_valid_res_nxt;
    out_face_r      <= out_face_nxt;
    out_tx_r        <= out_tx_nxt;
    out_ty_r        <= out_ty_nxt;
    out_idx_r       <= out_idx_nxt;
  end

  assign out_if.valid       = out_v_r;
  assign out_if.valid_res   = out_valid_res_r;
  assign out_if.face        = out_face_r;
  assign out_if.texel_x     = out_tx_r;
  assign out_if.texel_y     = out_ty_r;
  assign out_if.texel_index = out_idx_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DIV_STAGES-1] && dlast.nonzero |-> dlast.rem_u < dlast.den && dlast.rem_v < dlast.den)
    else $error("divider remainder not below divisor");

  assert property (@(posedge clk) disable iff (!rst_n)
    clp_v_r && clp_r.nonzero |-> {1'b0, clp_r.tx} < clp_r.size && {1'b0, clp_r.ty} < clp_r.size)
    else $error("texel outside face after clamp");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_valid_res_r |-> out_face_r == FACE_POS_X && out_tx_r == '0 &&
                                    out_ty_r == '0 && out_idx_r == '0)
    else $error("zero direction result not cleared");

endmodule
